// ===== rtl/core/moe_rt_pkg.sv =====
// Shared types, op codes and exp table function for the top-k softmax router.
package moe_rt_pkg;

  // Logit and result field widths
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned EXPERT_W = 6;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned CFG_W    = 4;

  // exp table entries are Q0.16 with entry 0 equal to 1.0 (needs 17 bits)
  localparam int unsigned EXP_W    = 17;
  // quotient bits of the weight divide: the weight never exceeds 1.0
  localparam int unsigned QUOT_W   = 17;
  localparam logic [31:0] EXP_STEP_RATIO = 32'd4034748382;

  // Cell chain operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  // One entry of the sorted store
  typedef struct packed {
    logic                       valid;
    logic signed [SCORE_W-1:0]  score;
    logic [EXPERT_W-1:0]        expert;
  } entry_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic [1:0]                 op;
    logic                       en;
    logic signed [SCORE_W-1:0]  score;
    logic [EXPERT_W-1:0]        expert;
  } cell_ctl_t;

  // Divider result
  typedef struct packed {
    logic                       done;
    logic [QUOT_W-1:0]          quot;
  } div_res_t;

  // exp(-idx/16) in Q0.16, built by repeated Q0.32 multiplication (elaboration only)
  function automatic logic [EXP_W-1:0] exp_entry(input int idx);
    logic [79:0] t;
    logic [79:0] r;
    t = 80'd1 << 32;
    for (int i = 1; i <= idx; i++) begin
      t = ((t * {48'd0, EXP_STEP_RATIO}) + (80'd1 << 31)) >> 32;
    end
    r = (t + (80'd1 << 15)) >> 16;
    return r[EXP_W-1:0];
  endfunction

endpackage

// ===== rtl/core/moe_rt_cell.sv =====
// One cell of the sorted top-k chain: holds one score and expert number.
module moe_rt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  moe_rt_pkg::cell_ctl_t ctl,
  input  logic                 in_range,
  input  moe_rt_pkg::entry_t   up,
  input  logic                 up_ins,
  input  moe_rt_pkg::entry_t   below,
  output moe_rt_pkg::entry_t   cur,
  output logic                 ins
);

  moe_rt_pkg::entry_t cur_r;
  moe_rt_pkg::entry_t cur_nxt;
  logic               gt;

  // New score ranks above this entry (empty slot always loses; ties keep old)
  always_comb begin
    gt  = !cur_r.valid || (ctl.score > cur_r.score);
    ins = (ctl.op == moe_rt_pkg::OP_INSERT) && ctl.en && in_range && gt;
  end

  // Next entry: shift down on insert, shift up on rotate/pop
  always_comb begin
    cur_nxt = cur_r;
    unique case (ctl.op)
      moe_rt_pkg::OP_INSERT: begin
        if (up_ins) begin
          cur_nxt = up;
        end else if (ins) begin
          cur_nxt.valid  = 1'b1;
          cur_nxt.score  = ctl.score;
          cur_nxt.expert = ctl.expert;
        end
        cur_nxt.valid = cur_nxt.valid && in_range;
      end
      moe_rt_pkg::OP_ROTATE,
      moe_rt_pkg::OP_POP: begin
        cur_nxt = below;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

// ===== rtl/core/moe_rt_div.sv =====
// Restoring divider for the weight: (e * 2^16 + sum/2) / sum, one bit per cycle.
module moe_rt_div #(
  parameter int unsigned SUM_W = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [moe_rt_pkg::EXP_W-1:0]    num_e,
  input  logic [SUM_W-1:0]                den,
  output moe_rt_pkg::div_res_t            res
);

  localparam int unsigned QW    = moe_rt_pkg::QUOT_W;
  localparam int unsigned NUM_W = moe_rt_pkg::EXP_W + 16 + 1;
  localparam int unsigned CW    = $clog2(QW + 1);

  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] den_r;
  logic [QW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] num;
  logic [SUM_W:0]   trial;
  logic             qbit;

  // Rounded numerator; its upper part is already below the divisor
  assign num = {1'b0, num_e, 16'd0} + NUM_W'(den >> 1);

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    trial    = {rem_r, lo_r[QW-1]};
    qbit     = (trial >= {1'b0, den_r});
    if (start) begin
      rem_nxt  = SUM_W'(num[NUM_W-1:QW]);
      lo_nxt   = num[QW-1:0];
      cnt_nxt  = CW'(QW);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      rem_nxt  = qbit ? SUM_W'(trial - {1'b0, den_r}) : trial[SUM_W-1:0];
      lo_nxt   = {lo_r[QW-2:0], qbit};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign res.done = done_r;
  assign res.quot = lo_r;

endmodule

// ===== rtl/core/moe_topk_softmax_router.sv =====
// Top level of the top-k softmax gating router: cell chain, exp table, control.
//
// Usage: one token's router logits enter on the in_ stream, one per
// transaction, in expert order (signed Q8.8), with in_tlast on the final
// one. A chain of MAX_TOP_K cells keeps the k largest logits sorted as
// they arrive, one logit per cycle. On the last logit the block stops
// taking input, rotates the chain once to sum the exp table values of
// the kept experts, then for each kept expert runs a bit-serial divide
// and presents one result on out_: expert number and Q0.16 weight,
// highest logit first, out_tlast on the last. The serial divider
// sets the emission rate.
// The result sits in an output register, so the next token's logits are
// taken while the final result waits. A stalled receiver holds the
// divider result until the output register frees up.
// k comes from the cfg_ channel (4 bits, reset 2; 0 acts as 1, above
// MAX_TOP_K acts as MAX_TOP_K). Reset empties the chain, zeroes the
// expert count and sets k to 2.
module moe_topk_softmax_router #(
  parameter int unsigned MAX_EXPERTS     = 64,
  parameter int unsigned MAX_TOP_K       = 8,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] logit
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [5:0] expert_index, [21:6] route_weight, [23:22] zero
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cfg_data: [3:0] experts_chosen
  input  logic [3:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  localparam int unsigned KW    = $clog2(MAX_TOP_K + 1);
  localparam int unsigned CNT_W = $clog2(MAX_TOP_K + 1);
  localparam int unsigned ECW   = $clog2(MAX_EXPERTS + 1);
  localparam int unsigned AW    = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned EW    = moe_rt_pkg::EXP_W;
  localparam int unsigned SUM_W = EW + $clog2(MAX_TOP_K);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_SUM     = 3'd1;
  localparam logic [2:0] S_START   = 3'd2;
  localparam logic [2:0] S_WAIT    = 3'd3;

  logic [2:0]                  state_r, state_nxt;
  logic [3:0]                  cfg_k_r;
  logic [KW-1:0]               k_eff;
  logic [ECW-1:0]              ecnt_r, ecnt_nxt;
  logic [CNT_W-1:0]            rot_r, rot_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic signed [15:0]          top_r, top_nxt;
  logic                        in_acc;
  logic                        load_out;
  moe_rt_pkg::cell_ctl_t       ctl;
  moe_rt_pkg::entry_t          ent [MAX_TOP_K+1];
  logic [MAX_TOP_K-1:0]        ins_w;
  logic [MAX_TOP_K:0]          vld_vec;
  logic [MAX_TOP_K:0]          range_vec;
  logic [EW-1:0]               exp_rom [EXP_TABLE_DEPTH];
  logic [16:0]                 diff_w;
  logic [11:0]                 tab_idx;
  logic [EW-1:0]               e0;
  moe_rt_pkg::div_res_t        div_res;
  logic                        out_valid_r;
  logic [5:0]                  out_expert_r;
  logic [15:0]                 out_weight_r;
  logic                        out_last_r;

  // Configuration register and effective k
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      cfg_k_r <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_k_r == 4'd0) begin
      k_eff = KW'(1);
    end else if ({1'b0, cfg_k_r} > 5'(MAX_TOP_K)) begin
      k_eff = KW'(MAX_TOP_K);
    end else begin
      k_eff = KW'(cfg_k_r);
    end
  end

  // exp table, built at elaboration
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = moe_rt_pkg::exp_entry(g);
  end

  // Table lookup for the entry at the head of the chain
  always_comb begin
    diff_w  = {top_r[15], top_r} - {ent[0].score[15], ent[0].score};
    tab_idx = diff_w[15:4];
    e0      = '0;
    if (ent[0].valid && ({1'b0, tab_idx} < 13'(EXP_TABLE_DEPTH))) begin
      e0 = exp_rom[tab_idx[AW-1:0]];
    end
  end

  // Chain control
  assign in_tready = (state_r == S_COLLECT);
  assign in_acc    = in_tvalid && in_tready;
  assign load_out  = (state_r == S_WAIT) && div_res.done && (!out_valid_r || out_tready);

  always_comb begin
    ctl.en     = (ecnt_r < ECW'(MAX_EXPERTS));
    ctl.score  = in_tdata;
    ctl.expert = 6'(ecnt_r);
    if (in_acc) begin
      ctl.op = moe_rt_pkg::OP_INSERT;
    end else if (state_r == S_SUM) begin
      ctl.op = moe_rt_pkg::OP_ROTATE;
    end else if (load_out) begin
      ctl.op = moe_rt_pkg::OP_POP;
    end else begin
      ctl.op = moe_rt_pkg::OP_HOLD;
    end
  end

  // Cell chain
  assign ent[MAX_TOP_K]       = '0;
  assign vld_vec[MAX_TOP_K]   = 1'b0;
  assign range_vec[MAX_TOP_K] = 1'b0;

  for (genvar i = 0; i < MAX_TOP_K; i++) begin : g_cell
    moe_rt_pkg::entry_t up_e;
    moe_rt_pkg::entry_t below_e;
    logic               up_ins;

    if (i == 0) begin : g_head
      assign up_e   = '0;
      assign up_ins = 1'b0;
    end else begin : g_body
      assign up_e   = ent[i-1];
      assign up_ins = ins_w[i-1];
    end

    if (i == MAX_TOP_K - 1) begin : g_tail
      assign below_e = (ctl.op == moe_rt_pkg::OP_ROTATE) ? ent[0] : ent[i+1];
    end else begin : g_mid
      assign below_e = ent[i+1];
    end

    assign range_vec[i] = (KW'(i) < k_eff);
    assign vld_vec[i]   = ent[i].valid;

    moe_rt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .in_range (range_vec[i]),
      .up       (up_e),
      .up_ins   (up_ins),
      .below    (below_e),
      .cur      (ent[i]),
      .ins      (ins_w[i])
    );
  end

  // Weight divider
  moe_rt_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .num_e (e0),
    .den   (sum_r),
    .res   (div_res)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ecnt_nxt  = ecnt_r;
    rot_nxt   = rot_r;
    sum_nxt   = sum_r;
    top_nxt   = top_r;
    unique case (state_r)
      S_COLLECT: begin
        if (in_acc) begin
          ecnt_nxt = ctl.en ? ecnt_r + ECW'(1) : ecnt_r;
          if (in_tlast) begin
            ecnt_nxt  = '0;
            rot_nxt   = '0;
            sum_nxt   = '0;
            top_nxt   = ins_w[0] ? in_tdata : ent[0].score;
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        sum_nxt = sum_r + SUM_W'(e0);
        rot_nxt = rot_r + CNT_W'(1);
        if (rot_r == CNT_W'(MAX_TOP_K - 1)) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (load_out) begin
          state_nxt = ent[1].valid ? S_START : S_COLLECT;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      ecnt_r  <= '0;
      rot_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
      rot_r   <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    top_r <= top_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_expert_r <= ent[0].expert;
      out_weight_r <= div_res.quot[16] ? 16'hFFFF : div_res.quot[15:0];
      out_last_r   <= !ent[1].valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_weight_r, out_expert_r};
  assign out_tlast  = out_last_r;

  // Kept entries fill the chain from the head without gaps, except while it rotates
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_SUM |-> $onehot(vld_vec + 1'b1))
    else $error("cell chain has a gap");

  // No entry survives beyond k once the sum starts
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM && rot_r == '0 |-> (vld_vec & ~range_vec) == '0)
    else $error("entry kept beyond k");

  // Divider never starts on a zero sum
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_START |-> sum_r != '0)
    else $error("zero exp sum");

  // Chain is empty after the last result is loaded
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && !ent[1].valid |=> vld_vec == '0)
    else $error("chain not empty after last result");

endmodule
